// File: rtl/core/c128e_pkg.sv
// shared types, constants and symbol pattern table for the code 128 symbol encoder
package c128e_pkg;

  localparam int unsigned SymBits = 7;    // reduced symbol value, check sum, weights
  localparam int unsigned SumBits = 10;   // weighted partial sum before folding
  localparam int unsigned MaxFold = 7;    // largest multiple of the modulus to remove

  localparam logic [SymBits-1:0] CheckMod  = 7'd103;
  localparam logic [7:0]         StopValue = 8'd106;

  localparam logic [3:0] PatternLenShort = 4'd11;
  localparam logic [3:0] PatternLenStop  = 4'd13;
  localparam logic [3:0] PatternLenNone  = 4'd0;

  localparam logic [12:0] StopPattern = 13'b1100011101011;

  typedef struct packed {
    logic [7:0] symbol_value;
    logic       first_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic [12:0] module_pattern;
    logic [3:0]  pattern_length;
    logic        bad_value;
    logic [6:0]  running_check;
  } out_item_t;

  // 11-module patterns for values 0..105, first module in the msb
  function automatic logic [10:0] symbol_modules(input logic [6:0] value);
    logic [10:0] p;
    unique case (value)
      7'd0:   p = 11'b11011001100; 7'd1:   p = 11'b11001101100; 7'd2:   p = 11'b11001100110;
      7'd3:   p = 11'b10010011000; 7'd4:   p = 11'b10010001100; 7'd5:   p = 11'b10001001100;
      7'd6:   p = 11'b10011001000; 7'd7:   p = 11'b10011000100; 7'd8:   p = 11'b10001100100;
      7'd9:   p = 11'b11001001000; 7'd10:  p = 11'b11001000100; 7'd11:  p = 11'b11000100100;
      7'd12:  p = 11'b10110011100; 7'd13:  p = 11'b10011011100; 7'd14:  p = 11'b10011001110;
      7'd15:  p = 11'b10111001100; 7'd16:  p = 11'b10011101100; 7'd17:  p = 11'b10011100110;
      7'd18:  p = 11'b11001110010; 7'd19:  p = 11'b11001011100; 7'd20:  p = 11'b11001001110;
      7'd21:  p = 11'b11011100100; 7'd22:  p = 11'b11001110100; 7'd23:  p = 11'b11101101110;
      7'd24:  p = 11'b11101001100; 7'd25:  p = 11'b11100101100; 7'd26:  p = 11'b11100100110;
      7'd27:  p = 11'b11101100100; 7'd28:  p = 11'b11100110100; 7'd29:  p = 11'b11100110010;
      7'd30:  p = 11'b11011011000; 7'd31:  p = 11'b11011000110; 7'd32:  p = 11'b11000110110;
      7'd33:  p = 11'b10100011000; 7'd34:  p = 11'b10001011000; 7'd35:  p = 11'b10001000110;
      7'd36:  p = 11'b10110001000; 7'd37:  p = 11'b10001101000; 7'd38:  p = 11'b10001100010;
      7'd39:  p = 11'b11010001000; 7'd40:  p = 11'b11000101000; 7'd41:  p = 11'b11000100010;
      7'd42:  p = 11'b10110111000; 7'd43:  p = 11'b10110001110; 7'd44:  p = 11'b10001101110;
      7'd45:  p = 11'b10111011000; 7'd46:  p = 11'b10111000110; 7'd47:  p = 11'b10001110110;
      7'd48:  p = 11'b11101110110; 7'd49:  p = 11'b11010001110; 7'd50:  p = 11'b11000101110;
      7'd51:  p = 11'b11011101000; 7'd52:  p = 11'b11011100010; 7'd53:  p = 11'b11011101110;
      7'd54:  p = 11'b11101011000; 7'd55:  p = 11'b11101000110; 7'd56:  p = 11'b11100010110;
      7'd57:  p = 11'b11101101000; 7'd58:  p = 11'b11101100010; 7'd59:  p = 11'b11100011010;
      7'd60:  p = 11'b11101111010; 7'd61:  p = 11'b11001000010; 7'd62:  p = 11'b11110001010;
      7'd63:  p = 11'b10100110000; 7'd64:  p = 11'b10100001100; 7'd65:  p = 11'b10010110000;
      7'd66:  p = 11'b10010000110; 7'd67:  p = 11'b10000101100; 7'd68:  p = 11'b10000100110;
      7'd69:  p = 11'b10110010000; 7'd70:  p = 11'b10110000100; 7'd71:  p = 11'b10011010000;
      7'd72:  p = 11'b10011000010; 7'd73:  p = 11'b10000110100; 7'd74:  p = 11'b10000110010;
      7'd75:  p = 11'b11000010010; 7'd76:  p = 11'b11001010000; 7'd77:  p = 11'b11110111010;
      7'd78:  p = 11'b11000010100; 7'd79:  p = 11'b10001111010; 7'd80:  p = 11'b10100111100;
      7'd81:  p = 11'b10010111100; 7'd82:  p = 11'b10010011110; 7'd83:  p = 11'b10111100100;
      7'd84:  p = 11'b10011110100; 7'd85:  p = 11'b10011110010; 7'd86:  p = 11'b11110100100;
      7'd87:  p = 11'b11110010100; 7'd88:  p = 11'b11110010010; 7'd89:  p = 11'b11011011110;
      7'd90:  p = 11'b11011110110; 7'd91:  p = 11'b11110110110; 7'd92:  p = 11'b10101111000;
      7'd93:  p = 11'b10100011110; 7'd94:  p = 11'b10001011110; 7'd95:  p = 11'b10111101000;
      7'd96:  p = 11'b10111100010; 7'd97:  p = 11'b11110101000; 7'd98:  p = 11'b11110100010;
      7'd99:  p = 11'b10111011110; 7'd100: p = 11'b10111101110; 7'd101: p = 11'b11101011110;
      7'd102: p = 11'b11110101110; 7'd103: p = 11'b11010000100; 7'd104: p = 11'b11010010000;
      7'd105: p = 11'b11010011100;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/core/code128_symbol_encoder.sv
// code 128 symbol encoder: module pattern lookup and running mod-103 check sum
//
// usage
//   input channel: in_valid_i / in_stall_o with one in_item_t per item (symbol
//   value and a first-of-sequence flag); an item is taken on a rising edge with
//   in_valid_i high and in_stall_o low
//   output channel: out_valid_o / out_stall_i with one out_item_t per item
//   (left-aligned module pattern, its length, a bad-value flag, check sum so far)
// timing
//   three register stages: input register, lookup/weight stage, result register;
//   an item is taken into the input register, then moves to the lookup/weight
//   stage and on to the result register, each move waiting while the next stage
//   holds an item that cannot move on; one item per cycle sustained while
//   out_stall_i is low; the check sum loop closes in the result stage
//   with one add and a fold by parallel compares against multiples of 103
// reset
//   clears all valid bits and marks no sequence open, so the first item after
//   reset starts a sequence whether or not its flag is set
// stall behavior
//   a stalled result holds in the result register while the two stages before
//   it keep filling; in_stall_o rises only once all three stages hold items
module code128_symbol_encoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  c128e_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output c128e_pkg::out_item_t  out_item_o
);

  localparam int unsigned SymBits = c128e_pkg::SymBits;
  localparam int unsigned SumBits = c128e_pkg::SumBits;

  // stage valid bits
  logic s1_valid_q, s1_valid_d;
  logic s2_valid_q, s2_valid_d;
  logic out_valid_q, out_valid_d;

  // stage payloads
  c128e_pkg::in_item_t   s1_item_q;
  logic [12:0]           s2_pattern_q;
  logic [3:0]            s2_len_q;
  logic                  s2_bad_q;
  logic                  s2_start_q;
  logic [SymBits-1:0]    s2_vmod_q;
  logic [SumBits-1:0]    s2_sum_q;
  c128e_pkg::out_item_t  out_q, out_d;

  // check sum state: open sequence flag, per-bit weights w*2^i mod 103, sum
  logic                  open_q;
  logic [SymBits-1:0]    wgt_q [SymBits];
  logic [SymBits-1:0]    wgt_d [SymBits];
  logic [SymBits-1:0]    cs_q, cs_d;

  // handshake
  logic move_out, move1, in_ready, accept;

  assign move_out   = s2_valid_q && (!out_valid_q || !out_stall_i);
  assign move1      = s1_valid_q && (!s2_valid_q || move_out);
  assign in_ready   = !s1_valid_q || move1;
  assign in_stall_o = !in_ready;
  assign accept     = in_valid_i && in_ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (move1) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (move1) begin
      s2_valid_d = 1'b1;
    end else if (move_out) begin
      s2_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (move_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // stage 1: pattern lookup, value reduced mod 103, weighted partial sum
  logic [7:0]          s1_value;
  logic                s1_bad;
  logic                s1_stop;
  logic                s1_start;
  logic [SymBits-1:0]  s1_vmod;
  logic [SumBits-1:0]  s1_sum;
  logic [12:0]         s1_pattern;
  logic [3:0]          s1_len;

  assign s1_value = s1_item_q.symbol_value;
  assign s1_bad   = s1_value > c128e_pkg::StopValue;
  assign s1_stop  = s1_value == c128e_pkg::StopValue;
  assign s1_start = s1_item_q.first_of_sequence || !open_q;

  always_comb begin
    // value below 256 needs at most two subtractions of 103
    if (s1_value >= {c128e_pkg::CheckMod, 1'b0}) begin
      s1_vmod = SymBits'(s1_value - {c128e_pkg::CheckMod, 1'b0});
    end else if (s1_value >= {1'b0, c128e_pkg::CheckMod}) begin
      s1_vmod = SymBits'(s1_value - {1'b0, c128e_pkg::CheckMod});
    end else begin
      s1_vmod = s1_value[SymBits-1:0];
    end
  end

  always_comb begin
    if (s1_bad) begin
      s1_pattern = '0;
      s1_len     = c128e_pkg::PatternLenNone;
    end else if (s1_stop) begin
      s1_pattern = c128e_pkg::StopPattern;
      s1_len     = c128e_pkg::PatternLenStop;
    end else begin
      s1_pattern = {c128e_pkg::symbol_modules(s1_value[SymBits-1:0]), 2'b00};
      s1_len     = c128e_pkg::PatternLenShort;
    end
  end

  // weight * value as a sum of per-bit weights selected by the value bits
  always_comb begin
    s1_sum = '0;
    for (int i = 0; i < SymBits; i++) begin
      if (s1_vmod[i]) begin
        s1_sum = s1_sum + SumBits'(wgt_q[i]);
      end
    end
  end

  // next weights: restart at weight 1, otherwise step by 2^i mod 103
  always_comb begin
    logic [SymBits:0] step;
    for (int i = 0; i < SymBits; i++) begin
      step = {1'b0, wgt_q[i]} + ((SymBits+1)'(1) << i);
      if (s1_start) begin
        wgt_d[i] = SymBits'(1) << i;
      end else if (step >= {1'b0, c128e_pkg::CheckMod}) begin
        wgt_d[i] = SymBits'(step - {1'b0, c128e_pkg::CheckMod});
      end else begin
        wgt_d[i] = step[SymBits-1:0];
      end
    end
  end

  // result stage: close the check sum loop, fold by the largest fitting multiple
  logic [SumBits-1:0] fold_in, fold_out;

  assign fold_in = SumBits'(cs_q) + s2_sum_q;

  always_comb begin
    fold_out = fold_in;
    for (int j = 1; j <= c128e_pkg::MaxFold; j++) begin
      if (fold_in >= SumBits'(j * c128e_pkg::CheckMod)) begin
        fold_out = fold_in - SumBits'(j * c128e_pkg::CheckMod);
      end
    end
  end

  always_comb begin
    cs_d                   = s2_start_q ? s2_vmod_q : fold_out[SymBits-1:0];
    out_d.module_pattern   = s2_pattern_q;
    out_d.pattern_length   = s2_len_q;
    out_d.bad_value        = s2_bad_q;
    out_d.running_check    = s2_start_q ? '0 : fold_out[SymBits-1:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      open_q      <= 1'b0;
      cs_q        <= '0;
      for (int i = 0; i < SymBits; i++) begin
        wgt_q[i] <= '0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      if (move1) begin
        open_q <= 1'b1;
        wgt_q  <= wgt_d;
      end
      if (move_out) begin
        cs_q <= cs_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_item_i;
    end
    if (move1) begin
      s2_pattern_q <= s1_pattern;
      s2_len_q     <= s1_len;
      s2_bad_q     <= s1_bad;
      s2_start_q   <= s1_start;
      s2_vmod_q    <= s1_vmod;
      s2_sum_q     <= s1_sum;
    end
    if (move_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // reported check sum always lies inside the modulus
  a_check_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.running_check < c128e_pkg::CheckMod)
    else $error("running check out of range");

  // an out-of-range symbol gives an empty pattern
  a_bad_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.bad_value) |->
      (out_q.pattern_length == c128e_pkg::PatternLenNone && out_q.module_pattern == '0))
    else $error("bad value with nonempty pattern");

  // the item that opens a sequence reports a zero check sum
  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move_out && s2_start_q) |=> out_q.running_check == '0)
    else $error("sequence start reported nonzero check");

  // an empty input stage never stalls the sender
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("stall with empty input stage");

  // the base weight stays reduced mod 103
  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wgt_q[0] < c128e_pkg::CheckMod)
    else $error("weight out of range");

endmodule

// File: test/code128_symbol_encoder_tb.sv
// testbench for code128_symbol_encoder: directed symbol table, then random symbol runs
module code128_symbol_encoder_tb;

  localparam int unsigned IdleLimit   = 500;   // cycles with no item moving on either side
  localparam int unsigned RandomItems = 1200;
  localparam int unsigned DrainCycles = 6;     // three register stages plus margin
  localparam int unsigned Modulus     = 103;
  localparam int unsigned DirRows     = 20;

  localparam logic [12:0] StopBars = 13'b1100011101011;

  // bar/space modules of values 0..105, first module in the msb
  localparam logic [10:0] BarSpace [0:105] = '{
    11'b11011001100, 11'b11001101100, 11'b11001100110, 11'b10010011000, 11'b10010001100,
    11'b10001001100, 11'b10011001000, 11'b10011000100, 11'b10001100100, 11'b11001001000,
    11'b11001000100, 11'b11000100100, 11'b10110011100, 11'b10011011100, 11'b10011001110,
    11'b10111001100, 11'b10011101100, 11'b10011100110, 11'b11001110010, 11'b11001011100,
    11'b11001001110, 11'b11011100100, 11'b11001110100, 11'b11101101110, 11'b11101001100,
    11'b11100101100, 11'b11100100110, 11'b11101100100, 11'b11100110100, 11'b11100110010,
    11'b11011011000, 11'b11011000110, 11'b11000110110, 11'b10100011000, 11'b10001011000,
    11'b10001000110, 11'b10110001000, 11'b10001101000, 11'b10001100010, 11'b11010001000,
    11'b11000101000, 11'b11000100010, 11'b10110111000, 11'b10110001110, 11'b10001101110,
    11'b10111011000, 11'b10111000110, 11'b10001110110, 11'b11101110110, 11'b11010001110,
    11'b11000101110, 11'b11011101000, 11'b11011100010, 11'b11011101110, 11'b11101011000,
    11'b11101000110, 11'b11100010110, 11'b11101101000, 11'b11101100010, 11'b11100011010,
    11'b11101111010, 11'b11001000010, 11'b11110001010, 11'b10100110000, 11'b10100001100,
    11'b10010110000, 11'b10010000110, 11'b10000101100, 11'b10000100110, 11'b10110010000,
    11'b10110000100, 11'b10011010000, 11'b10011000010, 11'b10000110100, 11'b10000110010,
    11'b11000010010, 11'b11001010000, 11'b11110111010, 11'b11000010100, 11'b10001111010,
    11'b10100111100, 11'b10010111100, 11'b10010011110, 11'b10111100100, 11'b10011110100,
    11'b10011110010, 11'b11110100100, 11'b11110010100, 11'b11110010010, 11'b11011011110,
    11'b11011110110, 11'b11110110110, 11'b10101111000, 11'b10100011110, 11'b10001011110,
    11'b10111101000, 11'b10111100010, 11'b11110101000, 11'b11110100010, 11'b10111011110,
    11'b10111101110, 11'b11101011110, 11'b11110101110, 11'b11010000100, 11'b11010010000,
    11'b11010011100
  };

  // directed row; the result fields count only where typed is set
  typedef struct {
    logic [7:0]  symbol;
    logic        starts_run;
    bit          typed;
    logic [12:0] bars;
    logic [3:0]  bar_count;
    logic        bad;
    logic [6:0]  check;
  } dir_row_t;

  dir_row_t dir_rows [DirRows] = '{
    // no run open after reset: flag clear still starts one
    '{8'd0,   1'b0, 1'b1, 13'b1101100110000, 4'd11, 1'b0, 7'd0},
    '{8'd106, 1'b0, 1'b0, '0, '0, 1'b0, '0},
    '{8'd107, 1'b0, 1'b0, '0, '0, 1'b0, '0},   // smallest bad value inside a run
    '{8'd255, 1'b1, 1'b1, 13'd0, 4'd0, 1'b1, 7'd0},
    '{8'd255, 1'b0, 1'b0, '0, '0, 1'b0, '0},   // bad value still weighted, reduced mod 103
    '{8'd106, 1'b1, 1'b1, 13'b1100011101011, 4'd13, 1'b0, 7'd0},
    '{8'd105, 1'b0, 1'b0, '0, '0, 1'b0, '0},
    '{8'd104, 1'b0, 1'b0, '0, '0, 1'b0, '0},
    '{8'd103, 1'b0, 1'b0, '0, '0, 1'b0, '0},
    // repaired table entry
    '{8'd11,  1'b1, 1'b1, 13'b1100010010000, 4'd11, 1'b0, 7'd0},
    '{8'd1,   1'b0, 1'b0, '0, '0, 1'b0, '0},
    '{8'd102, 1'b0, 1'b0, '0, '0, 1'b0, '0},
    '{8'd128, 1'b0, 1'b0, '0, '0, 1'b0, '0},
    '{8'd64,  1'b0, 1'b0, '0, '0, 1'b0, '0},
    '{8'd85,  1'b0, 1'b0, '0, '0, 1'b0, '0},
    '{8'd170, 1'b0, 1'b0, '0, '0, 1'b0, '0},
    '{8'd42,  1'b1, 1'b0, '0, '0, 1'b0, '0},
    '{8'd106, 1'b0, 1'b0, '0, '0, 1'b0, '0},
    '{8'd0,   1'b1, 1'b1, 13'b1101100110000, 4'd11, 1'b0, 7'd0},
    '{8'd106, 1'b0, 1'b0, '0, '0, 1'b0, '0}
  };

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  c128e_pkg::in_item_t  in_item_i   = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  c128e_pkg::out_item_t out_item_o;

  // local copy of the check sum state
  logic [6:0] run_sum    = '0;
  logic [6:0] run_weight = '0;

  c128e_pkg::out_item_t pending_encodings [$];
  bit          quiet_phase = 1'b0;
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned runs_started = 0;
  int unsigned bad_symbols = 0;
  int unsigned stop_symbols = 0;
  int unsigned weight_wraps = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;

  code128_symbol_encoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // pattern lookup plus weighted mod-103 sum; updates the local run state
  function automatic c128e_pkg::out_item_t encode_symbol(input c128e_pkg::in_item_t item);
    c128e_pkg::out_item_t res;
    int unsigned          value;
    value = 32'(item.symbol_value);
    res = '0;
    if (item.symbol_value > c128e_pkg::StopValue) begin
      res.bad_value = 1'b1;
      bad_symbols++;
    end else if (item.symbol_value == c128e_pkg::StopValue) begin
      res.module_pattern = StopBars;
      res.pattern_length = c128e_pkg::PatternLenStop;
      stop_symbols++;
    end else begin
      res.module_pattern = {BarSpace[item.symbol_value[6:0]], 2'b00};
      res.pattern_length = c128e_pkg::PatternLenShort;
    end
    if (item.first_of_sequence || run_weight == 7'd0) begin
      run_sum = 7'(value % Modulus);
      run_weight = 7'd1;
      res.running_check = '0;
      runs_started++;
    end else begin
      run_sum = 7'((run_sum + run_weight * value) % Modulus);
      if (run_weight >= Modulus) begin
        run_weight = 7'd1;
        weight_wraps++;
      end else begin
        run_weight = run_weight + 7'd1;
      end
      res.running_check = run_sum;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    fail_count++;
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // one item: random gap, hold until taken, then queue what it should produce
  task automatic send_symbol(input c128e_pkg::in_item_t item, input bit typed,
                             input c128e_pkg::out_item_t typed_res);
    c128e_pkg::out_item_t predicted;
    int unsigned          gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    predicted = encode_symbol(item);
    pending_encodings.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  // result side: compare against the oldest pending item, draw stalls, watch for hangs
  always @(posedge clk_i) begin : result_side
    c128e_pkg::out_item_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("[%0t] no item moved for %0d cycles", $time, IdleLimit);
        $display("Simulation FAILED");
        $finish;
      end else begin
        if (out_valid_o && !out_stall_i) begin
          results_seen++;
          if (pending_encodings.size() == 0) begin
            report_mismatch("result with nothing pending, pattern",
                            32'(out_item_o.module_pattern), 0);
          end else begin
            want = pending_encodings.pop_front();
            if (out_item_o.module_pattern !== want.module_pattern)
              report_mismatch("module_pattern", 32'(out_item_o.module_pattern),
                              32'(want.module_pattern));
            if (out_item_o.pattern_length !== want.pattern_length)
              report_mismatch("pattern_length", 32'(out_item_o.pattern_length),
                              32'(want.pattern_length));
            if (out_item_o.bad_value !== want.bad_value)
              report_mismatch("bad_value", 32'(out_item_o.bad_value), 32'(want.bad_value));
            if (out_item_o.running_check !== want.running_check)
              report_mismatch("running_check", 32'(out_item_o.running_check),
                              32'(want.running_check));
          end
          stall_left = quiet_phase ? 0 : $urandom_range(0, 3);
        end else if (stall_left != 0) begin
          stall_left--;
        end
        out_stall_i <= (stall_left != 0);
      end
    end
  end

  initial begin : stimulus
    c128e_pkg::in_item_t  item;
    c128e_pkg::out_item_t typed_res;
    int unsigned          run_len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      item.symbol_value      = dir_rows[r].symbol;
      item.first_of_sequence = dir_rows[r].starts_run;
      typed_res = '{dir_rows[r].bars, dir_rows[r].bar_count, dir_rows[r].bad,
                    dir_rows[r].check};
      send_symbol(item, dir_rows[r].typed, typed_res);
    end

    // mostly flagged runs; some long enough to wrap the weight, a few with a
    // missing start flag or a stray flag in the middle
    while (items_sent < DirRows + RandomItems) begin
      quiet_phase = ($urandom_range(0, 4) == 0);
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(104, 230) : $urandom_range(1, 14);
      for (int k = 0; k < run_len && items_sent < DirRows + RandomItems; k++) begin
        if (k == 0)
          item.first_of_sequence = ($urandom_range(0, 9) != 0);
        else
          item.first_of_sequence = (run_len < 20) && ($urandom_range(0, 29) == 0);
        if ($urandom_range(0, 15) == 0)
          item.symbol_value = 8'($urandom_range(107, 255));
        else
          item.symbol_value = 8'($urandom_range(0, 106));
        send_symbol(item, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;
    quiet_phase = 1'b0;

    while (pending_encodings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d symbols in %0d runs (%0d bad, %0d stop), checked %0d results",
             items_sent, runs_started, bad_symbols, stop_symbols, results_seen);
    $display("check weight wrapped %0d times, %0d field mismatches", weight_wraps, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
